// File: sv/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared constants, register indexes and controller command types of the
// clamped PID regulator.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_WIDTH = 48;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 31;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int SPLIT     = ACC_WIDTH / 2;
  localparam int MUL_A_W   = DIFF_W + 1;
  localparam int MUL_B_W   = DATA_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int PACC_W    = ACC_WIDTH + DATA_W;
  localparam int TERM_W    = PACC_W - FRAC_BITS;
  localparam int SUM_W     = TERM_W + 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0]        TimeStepRst   = 31'd3277;
  localparam logic [STEP_W-1:0]        InvStepRst    = 31'd1310720;
  localparam logic signed [DATA_W-1:0] GainPRst      = 32'sd16384;
  localparam logic signed [DATA_W-1:0] GainIRst      = 32'sd7;
  localparam logic signed [DATA_W-1:0] GainDRst      = 32'sd655;
  localparam logic signed [DATA_W-1:0] LimitHighRst  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] LimitLowRst   = -32'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP  = 3'd0,
    CFG_INV_STEP   = 3'd1,
    CFG_GAIN_P     = 3'd2,
    CFG_GAIN_I     = 3'd3,
    CFG_GAIN_D     = 3'd4,
    CFG_LIMIT_HIGH = 3'd5,
    CFG_LIMIT_LOW  = 3'd6
  } cfg_index_e;

  typedef enum logic [2:0] {
    MUL_EDT,
    MUL_DINV,
    MUL_EGP,
    MUL_IHI,
    MUL_ILO,
    MUL_DHI,
    MUL_DLO
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SHADD
  } acc_op_e;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_LOAD,
    SUM_ADD
  } sum_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_EDT,
    ST_MUL_DINV,
    ST_MUL_EGP,
    ST_MUL_IHI,
    ST_MUL_ILO,
    ST_MUL_DHI,
    ST_MUL_DLO,
    ST_ACC_DLO,
    ST_ADD_D,
    ST_CLAMP
  } state_e;

  typedef struct packed {
    logic     ld_err;
    logic     ld_diff;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     int_upd;
    logic     der_ld;
    sum_op_e  sum_op;
    logic     out_ld;
  } pidc_cmd_t;

endpackage

// File: sv/pidc_ctrl.sv
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer of the PID regulator: steps the shared multiplier through the
// seven partial products and owns the request handshakes.
// ----------------------------------------------------------------------------
module pidc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pidc_pkg::pidc_cmd_t  cmd_o
);

  pidc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = pidc_pkg::MUL_EDT;
    cmd_o.acc_op  = pidc_pkg::ACC_HOLD;
    cmd_o.sum_op  = pidc_pkg::SUM_HOLD;
    case (state_q)
      pidc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_err = 1'b1;
          state_d      = pidc_pkg::ST_MUL_EDT;
        end
      end
      pidc_pkg::ST_MUL_EDT: begin
        cmd_o.mul_sel = pidc_pkg::MUL_EDT;
        cmd_o.ld_diff = 1'b1;
        state_d       = pidc_pkg::ST_MUL_DINV;
      end
      pidc_pkg::ST_MUL_DINV: begin
        cmd_o.mul_sel = pidc_pkg::MUL_DINV;
        cmd_o.acc_op  = pidc_pkg::ACC_LOAD;
        state_d       = pidc_pkg::ST_MUL_EGP;
      end
      pidc_pkg::ST_MUL_EGP: begin
        cmd_o.mul_sel = pidc_pkg::MUL_EGP;
        cmd_o.acc_op  = pidc_pkg::ACC_LOAD;
        cmd_o.int_upd = 1'b1;
        state_d       = pidc_pkg::ST_MUL_IHI;
      end
      pidc_pkg::ST_MUL_IHI: begin
        cmd_o.mul_sel = pidc_pkg::MUL_IHI;
        cmd_o.acc_op  = pidc_pkg::ACC_LOAD;
        cmd_o.der_ld  = 1'b1;
        state_d       = pidc_pkg::ST_MUL_ILO;
      end
      pidc_pkg::ST_MUL_ILO: begin
        cmd_o.mul_sel = pidc_pkg::MUL_ILO;
        cmd_o.acc_op  = pidc_pkg::ACC_LOAD;
        cmd_o.sum_op  = pidc_pkg::SUM_LOAD;
        state_d       = pidc_pkg::ST_MUL_DHI;
      end
      pidc_pkg::ST_MUL_DHI: begin
        cmd_o.mul_sel = pidc_pkg::MUL_DHI;
        cmd_o.acc_op  = pidc_pkg::ACC_SHADD;
        state_d       = pidc_pkg::ST_MUL_DLO;
      end
      pidc_pkg::ST_MUL_DLO: begin
        cmd_o.mul_sel = pidc_pkg::MUL_DLO;
        cmd_o.acc_op  = pidc_pkg::ACC_LOAD;
        cmd_o.sum_op  = pidc_pkg::SUM_ADD;
        state_d       = pidc_pkg::ST_ACC_DLO;
      end
      pidc_pkg::ST_ACC_DLO: begin
        cmd_o.acc_op = pidc_pkg::ACC_SHADD;
        state_d      = pidc_pkg::ST_ADD_D;
      end
      pidc_pkg::ST_ADD_D: begin
        cmd_o.sum_op = pidc_pkg::SUM_ADD;
        state_d      = pidc_pkg::ST_CLAMP;
      end
      pidc_pkg::ST_CLAMP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = pidc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pidc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_ready_o  = (state_q == pidc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/pidc_dpath.sv
// ----------------------------------------------------------------------------
// pidc_dpath
// Datapath of the PID regulator: configuration registers, error and
// integral state, one shared signed multiplier, product accumulator, term
// sum and output clamp.
// ----------------------------------------------------------------------------
module pidc_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pidc_pkg::pidc_cmd_t                  cmd_i,
  input  logic signed [pidc_pkg::DATA_W-1:0]   target_i,
  input  logic signed [pidc_pkg::DATA_W-1:0]   measured_i,
  input  logic                                 cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pidc_pkg::DATA_W-1:0]          cfg_data_i,
  output logic signed [pidc_pkg::DATA_W-1:0]   drive_o
);

  localparam int DW  = pidc_pkg::DATA_W;
  localparam int AW  = pidc_pkg::ACC_WIDTH;
  localparam int SW  = pidc_pkg::STEP_W;
  localparam int FW  = pidc_pkg::DIFF_W;
  localparam int MAW = pidc_pkg::MUL_A_W;
  localparam int MBW = pidc_pkg::MUL_B_W;
  localparam int PW  = pidc_pkg::PROD_W;
  localparam int QW  = pidc_pkg::PACC_W;
  localparam int TW  = pidc_pkg::TERM_W;
  localparam int UW  = pidc_pkg::SUM_W;
  localparam int SP  = pidc_pkg::SPLIT;

  logic [SW-1:0]        dt_q, inv_q;
  logic signed [DW-1:0] gp_q, gi_q, gd_q, lim_hi_q, lim_lo_q;

  logic signed [DW-1:0] e_q, e_d;
  logic signed [DW-1:0] last_q;
  logic signed [FW-1:0] d_q;
  logic signed [AW-1:0] es_q, es_d;
  logic signed [AW-1:0] deriv_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [QW-1:0] pacc_q, pacc_d;
  logic signed [UW-1:0] sum_q, sum_d;
  logic signed [DW-1:0] drive_q, drive_d;

  logic signed [FW-1:0]  err_raw;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [QW-1:0]  pacc_sh;
  logic signed [TW-1:0]  term;
  logic signed [AW:0]    es_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q     <= pidc_pkg::TimeStepRst;
      inv_q    <= pidc_pkg::InvStepRst;
      gp_q     <= pidc_pkg::GainPRst;
      gi_q     <= pidc_pkg::GainIRst;
      gd_q     <= pidc_pkg::GainDRst;
      lim_hi_q <= pidc_pkg::LimitHighRst;
      lim_lo_q <= pidc_pkg::LimitLowRst;
    end else if (cfg_we_i) begin
      case (pidc_pkg::cfg_index_e'(cfg_index_i))
        pidc_pkg::CFG_TIME_STEP:  dt_q     <= cfg_data_i[SW-1:0];
        pidc_pkg::CFG_INV_STEP:   inv_q    <= cfg_data_i[SW-1:0];
        pidc_pkg::CFG_GAIN_P:     gp_q     <= $signed(cfg_data_i);
        pidc_pkg::CFG_GAIN_I:     gi_q     <= $signed(cfg_data_i);
        pidc_pkg::CFG_GAIN_D:     gd_q     <= $signed(cfg_data_i);
        pidc_pkg::CFG_LIMIT_HIGH: lim_hi_q <= $signed(cfg_data_i);
        pidc_pkg::CFG_LIMIT_LOW:  lim_lo_q <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q   <= '0;
      last_q <= '0;
    end else begin
      es_q <= es_d;
      if (cmd_i.out_ld) begin
        last_q <= e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    prod_q <= prod_d;
    pacc_q <= pacc_d;
    sum_q  <= sum_d;
    drive_q <= drive_d;
    if (cmd_i.ld_diff) begin
      d_q <= FW'(e_q) - FW'(last_q);
    end
    if (cmd_i.der_ld) begin
      deriv_q <= term[AW-1:0];
    end
  end

  // The error saturates to the 32-bit range.
  always_comb begin
    err_raw = FW'(target_i) - FW'(measured_i);
    e_d     = e_q;
    if (cmd_i.ld_err) begin
      if (err_raw[FW-1] != err_raw[FW-2]) begin
        e_d = err_raw[FW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        e_d = err_raw[DW-1:0];
      end
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      pidc_pkg::MUL_EDT: begin
        mul_a = MAW'(e_q);
        mul_b = $signed({{(MBW-SW){1'b0}}, dt_q});
      end
      pidc_pkg::MUL_DINV: begin
        mul_a = MAW'(d_q);
        mul_b = $signed({{(MBW-SW){1'b0}}, inv_q});
      end
      pidc_pkg::MUL_EGP: begin
        mul_a = MAW'(e_q);
        mul_b = MBW'(gp_q);
      end
      pidc_pkg::MUL_IHI: begin
        mul_a = MAW'($signed(es_q[AW-1:SP]));
        mul_b = MBW'(gi_q);
      end
      pidc_pkg::MUL_ILO: begin
        mul_a = $signed({{(MAW-SP){1'b0}}, es_q[SP-1:0]});
        mul_b = MBW'(gi_q);
      end
      pidc_pkg::MUL_DHI: begin
        mul_a = MAW'($signed(deriv_q[AW-1:SP]));
        mul_b = MBW'(gd_q);
      end
      pidc_pkg::MUL_DLO: begin
        mul_a = $signed({{(MAW-SP){1'b0}}, deriv_q[SP-1:0]});
        mul_b = MBW'(gd_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    case (cmd_i.acc_op)
      pidc_pkg::ACC_LOAD:  pacc_d = QW'(prod_q);
      pidc_pkg::ACC_SHADD: pacc_d = (pacc_q <<< SP) + QW'(prod_q);
      default:             pacc_d = pacc_q;
    endcase
  end

  // Arithmetic shift of the exact product rounds toward minus infinity.
  assign pacc_sh = pacc_q >>> pidc_pkg::FRAC_BITS;
  assign term    = pacc_sh[TW-1:0];

  always_comb begin
    es_raw = (AW + 1)'(es_q) + (AW + 1)'($signed(term[AW-1:0]));
    es_d   = es_q;
    if (cmd_i.int_upd) begin
      if (es_raw[AW] != es_raw[AW-1]) begin
        es_d = es_raw[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
        es_d = es_raw[AW-1:0];
      end
    end
  end

  always_comb begin
    case (cmd_i.sum_op)
      pidc_pkg::SUM_LOAD: sum_d = UW'(term);
      pidc_pkg::SUM_ADD:  sum_d = sum_q + UW'(term);
      default:            sum_d = sum_q;
    endcase
  end

  always_comb begin
    drive_d = drive_q;
    if (cmd_i.out_ld) begin
      if (sum_q > UW'(lim_hi_q)) begin
        drive_d = lim_hi_q;
      end else if (sum_q < UW'(lim_lo_q)) begin
        drive_d = lim_lo_q;
      end else begin
        drive_d = sum_q[DW-1:0];
      end
    end
  end

  assign drive_o = drive_q;

endmodule

// File: sv/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Discrete PID regulator in signed Q16.16 with saturating integral and a
// clamped drive output.
//
//   channel  direction  handshake                payload
//   input    in         in_valid_i / in_ready_o   target_i, measured_i
//   output   out        out_valid_o / out_ready_i drive_o
//   config   in         cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// One request runs from acceptance to a valid drive through the single shared
// 34x33 multiplier, which forms seven partial products in turn.
// A new request is taken the cycle after the result is loaded; the result
// register lets the next request start while the drive still waits.
// The last step stalls only when a previous drive has not been taken.
// Reset restores the register defaults and clears the integral and the
// previous error.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [pidc_pkg::DATA_W-1:0]   target_i,
  input  logic signed [pidc_pkg::DATA_W-1:0]   measured_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pidc_pkg::DATA_W-1:0]   drive_o,
  input  logic                                 cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pidc_pkg::DATA_W-1:0]          cfg_data_i
);

  pidc_pkg::pidc_cmd_t cmd;

  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  pidc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .target_i    (target_i),
    .measured_i  (measured_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .drive_o     (drive_o)
  );

endmodule

// File: sim/tb_pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// tb_pid_controller_clamped
// Self-checking testbench of the clamped PID regulator. A predictor in this
// file tracks the register settings, the integral and the previous error,
// and works out the expected drive for every accepted request. A checker
// compares each drive taken from the block with the oldest expected value.
// Directed cases cover reset defaults, field extremes and register corners.
// Random traffic then runs under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                       CYCLE_LIMIT    = 400000;
  localparam int                       ITEMS_PER_SET  = 150;
  localparam int                       REPORT_MAX     = 10;
  localparam logic [pidc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam logic signed [pidc_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [pidc_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam longint ACC_MAX = (64'sd1 <<< (pidc_pkg::ACC_WIDTH - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  logic                                 clk_i;
  logic                                 rst_ni       = 1'b0;
  logic                                 in_valid_i   = 1'b0;
  logic                                 in_ready_o;
  logic signed [pidc_pkg::DATA_W-1:0]   target_i     = '0;
  logic signed [pidc_pkg::DATA_W-1:0]   measured_i   = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i  = 1'b0;
  logic signed [pidc_pkg::DATA_W-1:0]   drive_o;
  logic                                 cfg_we_i     = 1'b0;
  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index_i  = '0;
  logic [pidc_pkg::DATA_W-1:0]          cfg_data_i   = '0;

  pid_controller_clamped u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .target_i    (target_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  logic [pidc_pkg::STEP_W-1:0]          shadow_dt     = pidc_pkg::TimeStepRst;
  logic [pidc_pkg::STEP_W-1:0]          shadow_inv_dt = pidc_pkg::InvStepRst;
  logic signed [pidc_pkg::DATA_W-1:0]   shadow_kp     = pidc_pkg::GainPRst;
  logic signed [pidc_pkg::DATA_W-1:0]   shadow_ki     = pidc_pkg::GainIRst;
  logic signed [pidc_pkg::DATA_W-1:0]   shadow_kd     = pidc_pkg::GainDRst;
  logic signed [pidc_pkg::DATA_W-1:0]   shadow_hi     = pidc_pkg::LimitHighRst;
  logic signed [pidc_pkg::DATA_W-1:0]   shadow_lo     = pidc_pkg::LimitLowRst;
  longint                               integ_acc     = 0;
  longint                               prev_err      = 0;

  logic signed [pidc_pkg::DATA_W-1:0]   drive_expect_q[$];
  logic signed [pidc_pkg::DATA_W-1:0]   drive_want;
  int                                   fault_count   = 0;
  int                                   cycle_count   = 0;
  int                                   send_idle_pct = 0;
  int                                   recv_idle_pct = 0;
  longint                               track_sp      = 0;
  longint                               track_pv      = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_expect_q.size() == 0) begin
        if (fault_count < REPORT_MAX) $display("unexpected drive %0d", drive_o);
        fault_count++;
      end else begin
        drive_want = drive_expect_q.pop_front();
        if (drive_o !== drive_want) begin
          if (fault_count < REPORT_MAX) begin
            $display("drive mismatch: expected %0d, got %0d", drive_want, drive_o);
          end
          fault_count++;
        end
      end
    end
  end

  function automatic longint scaled_mul(longint a, longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> pidc_pkg::FRAC_BITS;
    if (prod[127:63] != {65{prod[127]}}) begin
      return prod[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return prod[63:0];
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [pidc_pkg::DATA_W-1:0] predict_drive(
    logic signed [pidc_pkg::DATA_W-1:0] tgt, logic signed [pidc_pkg::DATA_W-1:0] meas);
    longint err;
    longint acc;
    longint deriv;
    longint total;
    err = longint'(tgt) - longint'(meas);
    if (err > longint'(WORD_MAX)) err = longint'(WORD_MAX);
    if (err < longint'(WORD_MIN)) err = longint'(WORD_MIN);
    acc = add_sat64(integ_acc, scaled_mul(err, longint'(shadow_dt)));
    if (acc > ACC_MAX) acc = ACC_MAX;
    if (acc < ACC_MIN) acc = ACC_MIN;
    integ_acc = acc;
    deriv = scaled_mul(err - prev_err, longint'(shadow_inv_dt));
    total = scaled_mul(err, longint'(shadow_kp));
    total = add_sat64(total, scaled_mul(integ_acc, longint'(shadow_ki)));
    total = add_sat64(total, scaled_mul(deriv, longint'(shadow_kd)));
    if (total > longint'(shadow_hi)) begin
      total = longint'(shadow_hi);
    end else if (total < longint'(shadow_lo)) begin
      total = longint'(shadow_lo);
    end
    prev_err = err;
    return total[pidc_pkg::DATA_W-1:0];
  endfunction

  task automatic send_request(input logic signed [pidc_pkg::DATA_W-1:0] tgt,
                              input logic signed [pidc_pkg::DATA_W-1:0] meas);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_i   <= tgt;
    measured_i <= meas;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    drive_expect_q.push_back(predict_drive(tgt, meas));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pidc_pkg::DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      pidc_pkg::CFG_TIME_STEP:  shadow_dt     = data[pidc_pkg::STEP_W-1:0];
      pidc_pkg::CFG_INV_STEP:   shadow_inv_dt = data[pidc_pkg::STEP_W-1:0];
      pidc_pkg::CFG_GAIN_P:     shadow_kp     = data;
      pidc_pkg::CFG_GAIN_I:     shadow_ki     = data;
      pidc_pkg::CFG_GAIN_D:     shadow_kd     = data;
      pidc_pkg::CFG_LIMIT_HIGH: shadow_hi     = data;
      pidc_pkg::CFG_LIMIT_LOW:  shadow_lo     = data;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [pidc_pkg::DATA_W-1:0] corner_word();
    case ($urandom_range(4))
      0: return '0;
      1: return 32'd1;
      2: return WORD_MAX;
      3: return WORD_MIN;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [pidc_pkg::DATA_W-1:0] clip_word(longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return v[pidc_pkg::DATA_W-1:0];
  endfunction

  task automatic apply_setting(input int kind);
    logic signed [pidc_pkg::DATA_W-1:0] lim_a;
    logic signed [pidc_pkg::DATA_W-1:0] lim_b;
    logic signed [pidc_pkg::DATA_W-1:0] lim_t;
    wait_drained();
    case (kind)
      0: begin
        write_reg(pidc_pkg::CFG_TIME_STEP, $urandom_range(65536, 1));
        write_reg(pidc_pkg::CFG_INV_STEP, $urandom_range(1 << 22, 1));
        write_reg(pidc_pkg::CFG_GAIN_P, $urandom_range(1 << 20) - (1 << 19));
        write_reg(pidc_pkg::CFG_GAIN_I, $urandom_range(1 << 16) - (1 << 15));
        write_reg(pidc_pkg::CFG_GAIN_D, $urandom_range(1 << 12) - (1 << 11));
        lim_a = $urandom_range(1 << 24);
        write_reg(pidc_pkg::CFG_LIMIT_HIGH, lim_a);
        write_reg(pidc_pkg::CFG_LIMIT_LOW, -lim_a);
      end
      1: begin
        write_reg(pidc_pkg::CFG_TIME_STEP, $urandom);
        write_reg(pidc_pkg::CFG_INV_STEP, $urandom);
        write_reg(pidc_pkg::CFG_GAIN_P, $urandom);
        write_reg(pidc_pkg::CFG_GAIN_I, $urandom);
        write_reg(pidc_pkg::CFG_GAIN_D, $urandom);
        lim_a = $urandom;
        lim_b = $urandom;
        if (lim_a < lim_b && $urandom_range(3) != 0) begin
          lim_t = lim_a;
          lim_a = lim_b;
          lim_b = lim_t;
        end
        write_reg(pidc_pkg::CFG_LIMIT_HIGH, lim_a);
        write_reg(pidc_pkg::CFG_LIMIT_LOW, lim_b);
      end
      2: begin
        write_reg(pidc_pkg::CFG_TIME_STEP, corner_word());
        write_reg(pidc_pkg::CFG_INV_STEP, corner_word());
        write_reg(pidc_pkg::CFG_GAIN_P, corner_word());
        write_reg(pidc_pkg::CFG_GAIN_I, corner_word());
        write_reg(pidc_pkg::CFG_GAIN_D, corner_word());
        write_reg(pidc_pkg::CFG_LIMIT_HIGH, corner_word());
        write_reg(pidc_pkg::CFG_LIMIT_LOW, corner_word());
      end
      default: begin
        write_reg(pidc_pkg::CFG_TIME_STEP, '0);
        write_reg(pidc_pkg::CFG_INV_STEP, '0);
        write_reg(pidc_pkg::CFG_GAIN_P, $urandom);
        write_reg(pidc_pkg::CFG_GAIN_I, $urandom);
        write_reg(pidc_pkg::CFG_GAIN_D, $urandom);
        write_reg(pidc_pkg::CFG_LIMIT_HIGH, WORD_MAX);
        write_reg(pidc_pkg::CFG_LIMIT_LOW, WORD_MIN);
      end
    endcase
    if ($urandom_range(1) == 0) write_reg(CFG_IDX_UNUSED, $urandom);
  endtask

  task automatic test_reset_defaults();
    send_request('0, '0);
    send_request(32'sd65536, '0);
    send_request(-32'sd65536, '0);
    send_request(32'sd131072, 32'sd65536);
    send_request(32'sd1000, -32'sd1000);
  endtask

  task automatic test_field_extremes();
    send_request(WORD_MAX, WORD_MIN);
    send_request(WORD_MIN, WORD_MAX);
    send_request(WORD_MAX, WORD_MAX);
    send_request(WORD_MIN, WORD_MIN);
    send_request('0, WORD_MIN);
    send_request(WORD_MIN, '0);
  endtask

  task automatic test_register_corners();
    // The integral holds and the derivative vanishes while both steps are zero.
    wait_drained();
    write_reg(pidc_pkg::CFG_TIME_STEP, '0);
    write_reg(pidc_pkg::CFG_INV_STEP, '0);
    write_reg(pidc_pkg::CFG_LIMIT_HIGH, WORD_MAX);
    write_reg(pidc_pkg::CFG_LIMIT_LOW, WORD_MIN);
    send_request(32'sd70000, '0);
    send_request(-32'sd70000, '0);
    // With crossed limits the upper clamp takes priority.
    wait_drained();
    write_reg(pidc_pkg::CFG_TIME_STEP, 32'd65536);
    write_reg(pidc_pkg::CFG_INV_STEP, 32'd65536);
    write_reg(pidc_pkg::CFG_LIMIT_HIGH, -32'sd100);
    write_reg(pidc_pkg::CFG_LIMIT_LOW, 32'sd100);
    send_request(32'sd50000, '0);
    send_request(-32'sd50000, '0);
    send_request('0, '0);
    // Largest gains and steps drive the integral into saturation.
    wait_drained();
    write_reg(pidc_pkg::CFG_TIME_STEP, WORD_MAX);
    write_reg(pidc_pkg::CFG_INV_STEP, WORD_MAX);
    write_reg(pidc_pkg::CFG_GAIN_P, WORD_MAX);
    write_reg(pidc_pkg::CFG_GAIN_I, WORD_MIN);
    write_reg(pidc_pkg::CFG_GAIN_D, WORD_MAX);
    write_reg(pidc_pkg::CFG_LIMIT_HIGH, WORD_MAX);
    write_reg(pidc_pkg::CFG_LIMIT_LOW, WORD_MIN);
    write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
    repeat (5) send_request(WORD_MAX, WORD_MIN);
    repeat (2) send_request(WORD_MIN, WORD_MAX);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    logic signed [pidc_pkg::DATA_W-1:0] tgt;
    logic signed [pidc_pkg::DATA_W-1:0] meas;
    int                                 pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int kind = 0; kind < 4; kind++) begin
      apply_setting(kind);
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          if ($urandom_range(19) == 0) begin
            track_sp = longint'($urandom_range(1 << 25)) - (1 << 24);
          end
          track_pv = track_pv + (track_sp - track_pv) / 4 +
                     longint'($urandom_range(2047)) - 1024;
          tgt  = clip_word(track_sp);
          meas = clip_word(track_pv);
        end else if (pick < 90) begin
          tgt  = $urandom;
          meas = $urandom;
        end else begin
          tgt  = corner_word();
          meas = corner_word();
        end
        send_request(tgt, meas);
        if ($urandom_range(199) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_register_corners();
    test_random_traffic(30, 62);
    test_random_traffic(62, 30);
    test_random_traffic(0, 0);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (drive_expect_q.size() != 0) begin
      $display("%0d expected drives never arrived", drive_expect_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
